[rtl/ray_triangle_intersection_defines.svh]
// Assertion macros shared by the ray/triangle tester RTL.
// No dependencies; included by the modules that carry checks.
`ifndef RAY_TRIANGLE_INTERSECTION_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECTION_DEFINES_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define RTI_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the next cycle
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RTI_ASSERT(lbl, cond, msg)
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/rti_pkg.sv]
// Shared types and constants of the ray/triangle tester.
// No dependencies.
`default_nettype none
package rti_pkg;
  localparam int COMP_BITS_DEF = 21;
  localparam int FRAC_BITS_DEF = 10;
  localparam int VEC_BITS      = 63;
  localparam int DIST_BITS     = 31;
  localparam int POINT_BITS    = 32;
  localparam int MIN_DET_BITS  = 40;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 64;

  // register map
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_MIN_DET  = 4'h0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_MIN_DIST = 4'h8;

  typedef struct packed {
    logic [VEC_BITS-1:0] ray_origin;
    logic [VEC_BITS-1:0] ray_direction;
    logic [VEC_BITS-1:0] vertex_a;
    logic [VEC_BITS-1:0] vertex_b;
    logic [VEC_BITS-1:0] vertex_c;
  } rti_in_t;

  typedef struct packed {
    logic                         hit;
    logic [DIST_BITS-1:0]         distance;
    logic signed [POINT_BITS-1:0] point_x;
    logic signed [POINT_BITS-1:0] point_y;
    logic signed [POINT_BITS-1:0] point_z;
  } rti_out_t;

  // control that travels with each item between units
  typedef struct packed {
    logic valid;
    logic miss;
  } rti_tag_t;
endpackage
`default_nettype wire

[rtl/ray_triangle_intersection.sv]
// Ray/triangle intersection tester, top level. Depends on rti_pkg,
// rti_geom, rti_div, rti_point and the defines header.
//
// Use: each input item holds a ray (origin, direction) and a triangle
// (three vertices), packed signed fixed point. Each item yields exactly one
// result item: hit, distance t and the hit point, all zero on a miss.
// Channels: in_valid/in_stall/in_data in, out_valid/out_stall/out_data out.
// An item moves at an edge with valid high and stall low.
// Stages: 7 geometry, 32 divider (a saturation check, then one quotient bit
// per stage) and 2 point.
// Throughput: one item per cycle while out_stall does not freeze the pipeline.
// Stall: when the result register holds an item and out_stall is high, the
// whole pipeline freezes and in_stall goes high; nothing is lost.
// Reset (rst_n low, synchronous): all valid bits clear, min_det_magnitude
// and min_distance return to 1. Registers sit at byte addresses 0 and 8
// on the APB-style port; write them only while the block is idle.
`default_nettype none
`include "ray_triangle_intersection_defines.svh"
module ray_triangle_intersection import rti_pkg::*; #(
  parameter int COMPONENT_BITS = COMP_BITS_DEF,
  parameter int FRACTION_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire rti_in_t                  in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output rti_out_t                      out_data,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0]      prdata,
  output logic                          pready
);
  localparam int CB = COMPONENT_BITS;
  localparam int DW = 3*CB + 6;

  logic [MIN_DET_BITS-1:0] min_det_r;
  logic [DIST_BITS-1:0]    min_dist_r;
  logic                    wr_en;
  logic                    en;

  rti_tag_t             g_tag, d_tag;
  logic [DW-1:0]        g_det, g_tnum;
  logic [3*CB-1:0]      g_org, g_dir, d_org, d_dir;
  logic [DIST_BITS-1:0] d_tq;

  // pipeline advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r  <= MIN_DET_BITS'(1);
      min_dist_r <= DIST_BITS'(1);
    end else if (wr_en) begin
      case (paddr)
        ADDR_MIN_DET:  min_det_r  <= pwdata[MIN_DET_BITS-1:0];
        ADDR_MIN_DIST: min_dist_r <= pwdata[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_MIN_DET:  prdata = CFG_DATA_BITS'(min_det_r);
      ADDR_MIN_DIST: prdata = CFG_DATA_BITS'(min_dist_r);
      default:       prdata = '0;
    endcase
  end

  rti_geom #(.CB(CB)) u_geom (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_data(in_data), .min_det(min_det_r),
    .tag_o(g_tag), .det_o(g_det), .tnum_o(g_tnum), .org_o(g_org), .dir_o(g_dir)
  );

  rti_div #(.CB(CB), .FB(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .tag_i(g_tag), .det_i(g_det), .tnum_i(g_tnum), .org_i(g_org), .dir_i(g_dir),
    .tag_o(d_tag), .tq_o(d_tq), .org_o(d_org), .dir_o(d_dir)
  );

  rti_point #(.CB(CB), .FB(FRACTION_BITS)) u_point (
    .clk(clk), .rst_n(rst_n), .en(en),
    .tag_i(d_tag), .tq_i(d_tq), .org_i(d_org), .dir_i(d_dir),
    .min_dist(min_dist_r), .out_valid(out_valid), .out_data(out_data)
  );

  // a reported hit never lies below the configured distance
  `RTI_ASSERT(a_hit_dist, !out_valid || !out_data.hit || (out_data.distance >= min_dist_r), "hit below min distance")
  // a miss carries all-zero fields
  `RTI_ASSERT(a_miss_zero, !out_valid || out_data.hit || ((out_data.distance == '0) && (out_data.point_x == '0) && (out_data.point_y == '0) && (out_data.point_z == '0)), "miss with nonzero fields")
endmodule
`default_nettype wire

[rtl/rti_geom.sv]
// Geometry front end: edges, cross products, the four triple products,
// sign normalization and the barycentric tests. Seven register stages.
// Depends on rti_pkg.
`default_nettype none
module rti_geom import rti_pkg::*; #(
  parameter int CB = COMP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire rti_in_t               in_data,
  input  wire logic [MIN_DET_BITS-1:0] min_det,
  output rti_tag_t                   tag_o,
  output logic [3*CB+5:0]            det_o,
  output logic [3*CB+5:0]            tnum_o,
  output logic [3*CB-1:0]            org_o,
  output logic [3*CB-1:0]            dir_o
);
  localparam int EB = CB + 1;
  localparam int PB = 2*CB + 2;
  localparam int QB = 2*CB + 3;
  localparam int MB = 2*CB + 1;
  localparam int DW = 3*CB + 6;
  localparam int CW = (DW > MIN_DET_BITS) ? DW : MIN_DET_BITS;

  logic signed [CB-1:0] o_c [3];
  logic signed [CB-1:0] d_c [3];
  logic signed [CB-1:0] a_c [3];
  logic signed [CB-1:0] b_c [3];
  logic signed [CB-1:0] c_c [3];

  logic signed [EB-1:0] s1_e1_r [3];
  logic signed [EB-1:0] s1_e2_r [3];
  logic signed [EB-1:0] s1_tv_r [3];
  logic signed [CB-1:0] s1_d_r [3];
  logic signed [CB-1:0] s1_o_r [3];

  logic signed [MB-1:0]   s2_pa_r [3];
  logic signed [MB-1:0]   s2_pb_r [3];
  logic signed [2*EB-1:0] s2_qa_r [3];
  logic signed [2*EB-1:0] s2_qb_r [3];
  logic signed [EB-1:0]   s2_e1_r [3];
  logic signed [EB-1:0]   s2_e2_r [3];
  logic signed [EB-1:0]   s2_tv_r [3];
  logic signed [CB-1:0]   s2_d_r [3];
  logic signed [CB-1:0]   s2_o_r [3];

  logic signed [PB-1:0] s3_p_r [3];
  logic signed [QB-1:0] s3_q_r [3];
  logic signed [EB-1:0] s3_e1_r [3];
  logic signed [EB-1:0] s3_e2_r [3];
  logic signed [EB-1:0] s3_tv_r [3];
  logic signed [CB-1:0] s3_d_r [3];
  logic signed [CB-1:0] s3_o_r [3];

  logic signed [DW-1:0] s4_det_r [3];
  logic signed [DW-1:0] s4_u_r [3];
  logic signed [DW-1:0] s4_v_r [3];
  logic signed [DW-1:0] s4_t_r [3];
  logic signed [CB-1:0] s4_d_r [3];
  logic signed [CB-1:0] s4_o_r [3];

  logic signed [DW-1:0] s5_det_r, s5_u_r, s5_v_r, s5_t_r;
  logic signed [DW-1:0] s6_det_r, s6_u_r, s6_v_r, s6_t_r;
  logic [3*CB-1:0]      s5_o_r, s5_d_r, s6_o_r, s6_d_r, s7_o_r, s7_d_r;
  logic [DW-1:0]        s7_det_r, s7_t_r;
  logic [6:1]           v_r;
  rti_tag_t             s7_tag_r;

  logic                 neg6;
  logic [CW-1:0]        det_cw;
  logic signed [DW:0]   uv_sum;
  logic                 miss_nxt;

  // per-component stages
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    assign o_c[i] = in_data.ray_origin[i*CB +: CB];
    assign d_c[i] = in_data.ray_direction[i*CB +: CB];
    assign a_c[i] = in_data.vertex_a[i*CB +: CB];
    assign b_c[i] = in_data.vertex_b[i*CB +: CB];
    assign c_c[i] = in_data.vertex_c[i*CB +: CB];

    always_ff @(posedge clk) begin
      if (en) begin
        // stage 1: edges and origin offset
        s1_e1_r[i] <= EB'(b_c[i]) - EB'(a_c[i]);
        s1_e2_r[i] <= EB'(c_c[i]) - EB'(a_c[i]);
        s1_tv_r[i] <= EB'(o_c[i]) - EB'(a_c[i]);
        s1_d_r[i]  <= d_c[i];
        s1_o_r[i]  <= o_c[i];
        // stage 2: cross product partial products
        s2_pa_r[i] <= MB'(s1_d_r[J]) * MB'(s1_e2_r[K]);
        s2_pb_r[i] <= MB'(s1_d_r[K]) * MB'(s1_e2_r[J]);
        s2_qa_r[i] <= (2*EB)'(s1_tv_r[J]) * (2*EB)'(s1_e1_r[K]);
        s2_qb_r[i] <= (2*EB)'(s1_tv_r[K]) * (2*EB)'(s1_e1_r[J]);
        s2_e1_r[i] <= s1_e1_r[i];
        s2_e2_r[i] <= s1_e2_r[i];
        s2_tv_r[i] <= s1_tv_r[i];
        s2_d_r[i]  <= s1_d_r[i];
        s2_o_r[i]  <= s1_o_r[i];
        // stage 3: pvec, qvec
        s3_p_r[i]  <= PB'(s2_pa_r[i]) - PB'(s2_pb_r[i]);
        s3_q_r[i]  <= QB'(s2_qa_r[i]) - QB'(s2_qb_r[i]);
        s3_e1_r[i] <= s2_e1_r[i];
        s3_e2_r[i] <= s2_e2_r[i];
        s3_tv_r[i] <= s2_tv_r[i];
        s3_d_r[i]  <= s2_d_r[i];
        s3_o_r[i]  <= s2_o_r[i];
        // stage 4: dot product terms
        s4_det_r[i] <= DW'(s3_e1_r[i]) * DW'(s3_p_r[i]);
        s4_u_r[i]   <= DW'(s3_tv_r[i]) * DW'(s3_p_r[i]);
        s4_v_r[i]   <= DW'(s3_d_r[i]) * DW'(s3_q_r[i]);
        s4_t_r[i]   <= DW'(s3_e2_r[i]) * DW'(s3_q_r[i]);
        s4_d_r[i]   <= s3_d_r[i];
        s4_o_r[i]   <= s3_o_r[i];
      end
    end
  end

  // stage 5: dot sums; stage 6: make det positive
  assign neg6 = s5_det_r[DW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_det_r <= s4_det_r[0] + s4_det_r[1] + s4_det_r[2];
      s5_u_r   <= s4_u_r[0] + s4_u_r[1] + s4_u_r[2];
      s5_v_r   <= s4_v_r[0] + s4_v_r[1] + s4_v_r[2];
      s5_t_r   <= s4_t_r[0] + s4_t_r[1] + s4_t_r[2];
      s5_o_r   <= {s4_o_r[2], s4_o_r[1], s4_o_r[0]};
      s5_d_r   <= {s4_d_r[2], s4_d_r[1], s4_d_r[0]};
      s6_det_r <= neg6 ? -s5_det_r : s5_det_r;
      s6_u_r   <= neg6 ? -s5_u_r : s5_u_r;
      s6_v_r   <= neg6 ? -s5_v_r : s5_v_r;
      s6_t_r   <= neg6 ? -s5_t_r : s5_t_r;
      s6_o_r   <= s5_o_r;
      s6_d_r   <= s5_d_r;
      s7_det_r <= s6_det_r;
      s7_t_r   <= s6_t_r;
      s7_o_r   <= s6_o_r;
      s7_d_r   <= s6_d_r;
    end
  end

  // stage 7: reject tests
  always_comb begin
    det_cw   = CW'(s6_det_r);
    uv_sum   = (DW+1)'(s6_u_r) + (DW+1)'(s6_v_r);
    miss_nxt = (s6_det_r == '0) || (det_cw < CW'(min_det))
            || s6_u_r[DW-1] || (s6_u_r > s6_det_r)
            || s6_v_r[DW-1] || (uv_sum > (DW+1)'(s6_det_r))
            || s6_t_r[DW-1];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      s7_tag_r <= '0;
    end else if (en) begin
      v_r            <= {v_r[5:1], in_valid};
      s7_tag_r.valid <= v_r[6];
      s7_tag_r.miss  <= miss_nxt;
    end
  end

  assign tag_o  = s7_tag_r;
  assign det_o  = s7_det_r;
  assign tnum_o = s7_t_r;
  assign org_o  = s7_o_r;
  assign dir_o  = s7_d_r;
endmodule
`default_nettype wire

[rtl/rti_div.sv]
// Pipelined restoring divider: t = floor(T * 2^FB / det), one quotient bit
// per stage after a saturation check. Depends on rti_pkg and the defines.
`default_nettype none
`include "ray_triangle_intersection_defines.svh"
module rti_div import rti_pkg::*; #(
  parameter int CB = COMP_BITS_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire rti_tag_t         tag_i,
  input  wire logic [3*CB+5:0]  det_i,
  input  wire logic [3*CB+5:0]  tnum_i,
  input  wire logic [3*CB-1:0]  org_i,
  input  wire logic [3*CB-1:0]  dir_i,
  output rti_tag_t              tag_o,
  output logic [DIST_BITS-1:0]  tq_o,
  output logic [3*CB-1:0]       org_o,
  output logic [3*CB-1:0]       dir_o
);
  localparam int DW = 3*CB + 6;
  localparam int RW = DW + FB + DIST_BITS;
  localparam int NS = DIST_BITS + 1;

  rti_tag_t             tag_r [NS];
  logic [RW-1:0]        rem_r [NS];
  logic [DW-1:0]        det_r [NS];
  logic [DIST_BITS-1:0] q_r [NS];
  logic                 sat_r [NS];
  logic [3*CB-1:0]      o_r [NS];
  logic [3*CB-1:0]      d_r [NS];

  logic [RW-1:0]        num0;

  // stage 0: scale numerator, check for quotient overflow
  assign num0 = RW'(tnum_i) << FB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num0;
      det_r[0] <= det_i;
      sat_r[0] <= num0 >= (RW'(det_i) << DIST_BITS);
      q_r[0]   <= (num0 >= (RW'(det_i) << DIST_BITS)) ? '1 : '0;
      o_r[0]   <= org_i;
      d_r[0]   <= dir_i;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k < NS; k++) begin : g_bit
    localparam int B = DIST_BITS - k;
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = RW'(det_r[k-1]) << B;
    assign take = !sat_r[k-1] && (rem_r[k-1] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= tag_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? rem_r[k-1] - dsh : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | (DIST_BITS'(take) << B);
        det_r[k] <= det_r[k-1];
        sat_r[k] <= sat_r[k-1];
        o_r[k]   <= o_r[k-1];
        d_r[k]   <= d_r[k-1];
      end
    end
  end

  assign tag_o = tag_r[NS-1];
  assign tq_o  = q_r[NS-1];
  assign org_o = o_r[NS-1];
  assign dir_o = d_r[NS-1];

  // a finished, unsaturated hit candidate leaves a remainder below det
  `RTI_ASSERT(a_div_rem, !tag_r[NS-1].valid || tag_r[NS-1].miss || sat_r[NS-1] || (rem_r[NS-1] < RW'(det_r[NS-1])), "divider remainder not below det")
endmodule
`default_nettype wire

[rtl/rti_point.sv]
// Back end: distance check, point = origin + floor(dir * t / 2^FB),
// saturation and the output register. Depends on rti_pkg.
`default_nettype none
module rti_point import rti_pkg::*; #(
  parameter int CB = COMP_BITS_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire rti_tag_t             tag_i,
  input  wire logic [DIST_BITS-1:0] tq_i,
  input  wire logic [3*CB-1:0]      org_i,
  input  wire logic [3*CB-1:0]      dir_i,
  input  wire logic [DIST_BITS-1:0] min_dist,
  output logic                      out_valid,
  output rti_out_t                  out_data
);
  localparam int PW = CB + DIST_BITS + 1;
  localparam int SW = PW + 1;

  logic                        p1_v_r, p1_hit_r;
  logic [DIST_BITS-1:0]        p1_tq_r;
  logic signed [PW-1:0]        p1_prod_r [3];
  logic signed [CB-1:0]        p1_o_r [3];
  logic signed [POINT_BITS-1:0] pt [3];
  logic                        out_valid_r;
  rti_out_t                    out_data_r;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [CB-1:0] dc;
    logic signed [PW-1:0] sh;
    logic signed [SW-1:0] sum;
    logic                 fits;

    assign dc = dir_i[i*CB +: CB];

    // stage 1: direction times distance
    always_ff @(posedge clk) begin
      if (en) begin
        p1_prod_r[i] <= PW'(dc) * PW'($signed({1'b0, tq_i}));
        p1_o_r[i]    <= org_i[i*CB +: CB];
      end
    end

    // stage 2: floor shift, add origin, clamp to 32 bits
    assign sh   = p1_prod_r[i] >>> FB;
    assign sum  = SW'(p1_o_r[i]) + SW'(sh);
    assign fits = (sum[SW-1:POINT_BITS-1] == '0) || (sum[SW-1:POINT_BITS-1] == '1);
    assign pt[i] = fits ? sum[POINT_BITS-1:0]
                 : (sum[SW-1] ? {1'b1, {(POINT_BITS-1){1'b0}}}
                              : {1'b0, {(POINT_BITS-1){1'b1}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_hit_r <= !tag_i.miss && (tq_i >= min_dist);
      p1_tq_r  <= tq_i;
      out_data_r.hit      <= p1_hit_r;
      out_data_r.distance <= p1_hit_r ? p1_tq_r : '0;
      out_data_r.point_x  <= p1_hit_r ? pt[0] : '0;
      out_data_r.point_y  <= p1_hit_r ? pt[1] : '0;
      out_data_r.point_z  <= p1_hit_r ? pt[2] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_v_r      <= tag_i.valid;
      out_valid_r <= p1_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire
